// ===== rtl/core/cgxy_pkg.sv =====
package cgxy_pkg;

    // Line buffer geometry and pixel format
    localparam int MAX_WIDTH  = 2048;
    localparam int PIXEL_BITS = 8;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int LINE_W     = 2 * PIXEL_BITS;
    localparam int GRAD_W     = PIXEL_BITS + 1;

    // Frame size registers
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_SIZE     = 3;
    localparam int WIDTH_W      = 12;
    localparam int HEIGHT_W     = 13;
    localparam int ROW_W        = 12;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int CMP_W        = ((ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W) + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_W;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Request actions
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Decoded request handed from the control to the datapath
    typedef struct packed {
        logic              rd;       // request reads the line buffer
        logic              pix;      // pixel request taken into the frame
        logic              first;    // pixel sits in column zero
        logic              seed;     // first flush of the bottom row
        logic              res;      // request yields at least one result
        logic              two;      // request yields a second result
        logic              gx_zero;  // first result has a border column
        logic              gy_zero;  // results have a border row
        logic              done;     // result is the frame's bottom right pixel
        logic [ADDR_W-1:0] addr;     // column written by a pixel request
    } t_step;

endpackage

// ===== rtl/core/cgxy_if.sv =====
interface cgxy_in_if;
    import cgxy_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, action, pixel, input ready);
    modport sink (input valid, action, pixel, output ready);
endinterface

interface cgxy_out_if;
    import cgxy_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     last_of_run;
    logic                     frame_done;

    modport source (output valid, grad_x, grad_y, last_of_run, frame_done, input ready);
    modport sink (input valid, grad_x, grad_y, last_of_run, frame_done, output ready);
endinterface

interface cgxy_cfg_if;
    import cgxy_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/central_difference_gradient_xy.sv =====
// Three-tap central-difference gradient over a raster stream of 8-bit pixels. Each pixel
// request (action 0) enters the frame; its results come out one row and one column late:
// grad_x is right minus left neighbour (zero on the first and last column), grad_y is
// below minus above (zero on the first and last row). After the frame's last pixel,
// pixels are dropped and each flush request (action 1) gives one result of the bottom
// row; the flush of the bottom right pixel raises frame_done and restarts the frame.
// Flushes at any other time are dropped. A request is taken every clock unless the result
// side stalls; a pixel in the last column yields two results and holds the input until
// the second moves on, since the single result register takes one result per unstalled
// clock. A request passes the work stage, then the result register. The two previous rows
// live in one MAX_WIDTH x 16 bit line buffer RAM (one write and one registered read port)
// that needs no clearing after reset. Writing frame_width or frame_height (clamped to
// 3..2048 and 3..4096) restarts the frame; write them only while the block is idle.
module central_difference_gradient_xy (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cgxy_in_if.sink           i_pix,
    cgxy_out_if.source        o_grad,
    cgxy_cfg_if.sink          i_cfg
);
    import cgxy_pkg::*;

    t_step             step;
    logic              in_fire;
    logic              in_ready;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LINE_W-1:0] ram_wdata;
    logic [LINE_W-1:0] ram_q;

    assign i_pix.ready = in_ready;
    assign in_fire     = i_pix.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    // Raster position, flush position and frame size
    cgxy_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .i_fire     (in_fire),
        .i_action   (i_pix.action),
        .o_step     (step),
        .o_rd_addr  (ram_raddr)
    );

    // Line buffer: above row in the upper byte, middle row in the lower byte
    cgxy_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (step.rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Differences and result register
    cgxy_calc u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_pixel    (i_pix.pixel),
        .i_ram_q    (ram_q),
        .i_o_ready  (o_grad.ready),
        .o_in_ready (in_ready),
        .o_wr_en    (ram_we),
        .o_wr_addr  (ram_waddr),
        .o_wr_data  (ram_wdata),
        .o_valid    (o_grad.valid),
        .o_grad_x   (o_grad.grad_x),
        .o_grad_y   (o_grad.grad_y),
        .o_last     (o_grad.last_of_run),
        .o_done     (o_grad.frame_done)
    );

    // A pending column write never collides with the next buffer read
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && step.rd |-> ram_waddr != ram_raddr)
        else $error("line buffer read and write hit the same column");

    // Only a request that yields a first result may yield a second one
    a_two_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.two |-> step.res && step.pix)
        else $error("second result decoded without a first one");

    // The bottom right result closes its run and lies on a border row
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_grad.valid && o_grad.frame_done |-> o_grad.last_of_run && o_grad.grad_y == '0)
        else $error("frame_done result malformed");

endmodule

// ===== rtl/core/cgxy_ram.sv =====
module cgxy_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/core/cgxy_ctrl.sv =====
module cgxy_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cgxy_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cgxy_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_fire,
    input  logic                            i_action,
    output cgxy_pkg::t_step                 o_step,
    output logic [cgxy_pkg::ADDR_W-1:0]     o_rd_addr
);
    import cgxy_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [ADDR_W-1:0]   r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_flushing;
    logic [ADDR_W-1:0]   r_fcol;

    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [CMP_W-1:0]    col_next;
    logic [CMP_W-1:0]    fcol_next;
    logic [HEIGHT_W-1:0] row_next;
    logic                row_end;
    logic                frame_end;
    logic                flush_end;
    logic                pix_eff;
    logic                fl_eff;

    // Clamp written frame sizes into range
    always_comb begin
        cfg_width = i_cfg_data[WIDTH_W-1:0];
        if (int'(cfg_width) < MIN_SIZE) begin
            cfg_width = WIDTH_W'(MIN_SIZE);
        end else if (int'(cfg_width) > MAX_WIDTH) begin
            cfg_width = WIDTH_W'(MAX_WIDTH);
        end
        cfg_height = i_cfg_data[HEIGHT_W-1:0];
        if (int'(cfg_height) < MIN_SIZE) begin
            cfg_height = HEIGHT_W'(MIN_SIZE);
        end else if (int'(cfg_height) > MAX_HEIGHT) begin
            cfg_height = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    // Position compares
    assign col_next  = CMP_W'(r_col) + CMP_W'(1);
    assign fcol_next = CMP_W'(r_fcol) + CMP_W'(1);
    assign row_next  = HEIGHT_W'(r_row) + HEIGHT_W'(1);
    assign row_end   = (col_next >= CMP_W'(r_width));
    assign frame_end = (row_next >= r_height);
    assign flush_end = (fcol_next >= CMP_W'(r_width));

    // Drop pixels during flush and flushes outside it
    assign pix_eff = i_fire && (i_action == ACT_PIXEL) && !r_flushing;
    assign fl_eff  = i_fire && (i_action == ACT_FLUSH) && r_flushing;

    // Decode the request for the datapath
    always_comb begin
        o_step.rd      = pix_eff || fl_eff;
        o_step.pix     = pix_eff;
        o_step.first   = pix_eff && (r_col == '0);
        o_step.seed    = fl_eff && (r_fcol == '0);
        o_step.res     = fl_eff || (pix_eff && (r_row != '0) && (r_col != '0));
        o_step.two     = pix_eff && row_end && (r_row != '0);
        o_step.gx_zero = r_flushing ? ((r_fcol == '0) || flush_end)
                                    : (r_col == ADDR_W'(1));
        o_step.gy_zero = r_flushing || (r_row == ROW_W'(1));
        o_step.done    = fl_eff && flush_end;
        o_step.addr    = r_col;
        o_rd_addr      = r_flushing ? (r_fcol + ADDR_W'(1)) : r_col;
    end

    // Advance raster position, flush position and frame size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_W'(WIDTH_RESET);
            r_height   <= HEIGHT_W'(HEIGHT_RESET);
            r_col      <= '0;
            r_row      <= '0;
            r_flushing <= 1'b0;
            r_fcol     <= '0;
        end else if (i_cfg_we && (i_cfg_idx == REG_FRAME_WIDTH ||
                                  i_cfg_idx == REG_FRAME_HEIGHT)) begin
            if (i_cfg_idx == REG_FRAME_WIDTH) begin
                r_width <= cfg_width;
            end else begin
                r_height <= cfg_height;
            end
            r_col      <= '0;
            r_row      <= '0;
            r_flushing <= 1'b0;
            r_fcol     <= '0;
        end else if (pix_eff) begin
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_flushing <= 1'b1;
                end else begin
                    r_row <= row_next[ROW_W-1:0];
                end
            end else begin
                r_col <= col_next[ADDR_W-1:0];
            end
        end else if (fl_eff) begin
            if (flush_end) begin
                r_col      <= '0;
                r_row      <= '0;
                r_flushing <= 1'b0;
                r_fcol     <= '0;
            end else begin
                r_fcol <= fcol_next[ADDR_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/cgxy_calc.sv =====
module cgxy_calc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cgxy_pkg::t_step                     i_step,
    input  logic [cgxy_pkg::PIXEL_BITS-1:0]     i_pixel,
    input  logic [cgxy_pkg::LINE_W-1:0]         i_ram_q,
    input  logic                                i_o_ready,
    output logic                                o_in_ready,
    output logic                                o_wr_en,
    output logic [cgxy_pkg::ADDR_W-1:0]         o_wr_addr,
    output logic [cgxy_pkg::LINE_W-1:0]         o_wr_data,
    output logic                                o_valid,
    output logic signed [cgxy_pkg::GRAD_W-1:0]  o_grad_x,
    output logic signed [cgxy_pkg::GRAD_W-1:0]  o_grad_y,
    output logic                                o_last,
    output logic                                o_done
);
    import cgxy_pkg::*;

    // History of the line buffer reads and of the row
    logic [PIXEL_BITS-1:0] r_h_mid;
    logic [PIXEL_BITS-1:0] r_pix_d;
    logic [PIXEL_BITS-1:0] r_first;

    // Pending line buffer write
    logic                  r_wr_en;
    logic [ADDR_W-1:0]     r_wr_addr;
    logic [PIXEL_BITS-1:0] r_wr_pix;

    // Work stage
    logic                  r_s1_valid;
    logic                  r_s1_phase;
    logic                  r_s1_two;
    logic                  r_s1_gx_zero;
    logic                  r_s1_gy_zero;
    logic                  r_s1_done;
    logic [PIXEL_BITS-1:0] r_s1_left;
    logic [PIXEL_BITS-1:0] r_s1_up;
    logic [PIXEL_BITS-1:0] r_s1_below;
    logic [PIXEL_BITS-1:0] r_s1_pix;

    // Result register
    logic                     r_o_valid;
    logic signed [GRAD_W-1:0] r_o_gx;
    logic signed [GRAD_W-1:0] r_o_gy;
    logic                     r_o_last;
    logic                     r_o_done;

    logic [PIXEL_BITS-1:0]    q_mid;
    logic [PIXEL_BITS-1:0]    q_above;
    logic                     out_free;
    logic                     s1_emit;
    logic                     s1_final;
    logic signed [GRAD_W-1:0] n_gx;
    logic signed [GRAD_W-1:0] n_gy;
    logic                     n_last;
    logic                     n_done;

    assign q_mid   = i_ram_q[PIXEL_BITS-1:0];
    assign q_above = i_ram_q[LINE_W-1:PIXEL_BITS];

    // Stage handshake: take a request whenever the stage empties
    assign out_free   = !r_o_valid || i_o_ready;
    assign s1_emit    = r_s1_valid && out_free;
    assign s1_final   = !(r_s1_two && !r_s1_phase);
    assign o_in_ready = !r_s1_valid || (s1_emit && s1_final);

    // Central differences; right tap and second-result upper tap come from the buffer read
    always_comb begin
        if (!r_s1_phase) begin
            n_gx   = r_s1_gx_zero ? '0
                   : $signed({1'b0, q_mid}) - $signed({1'b0, r_s1_left});
            n_gy   = r_s1_gy_zero ? '0
                   : $signed({1'b0, r_s1_below}) - $signed({1'b0, r_s1_up});
            n_last = !r_s1_two;
            n_done = r_s1_done;
        end else begin
            n_gx   = '0;
            n_gy   = r_s1_gy_zero ? '0
                   : $signed({1'b0, r_s1_pix}) - $signed({1'b0, q_above});
            n_last = 1'b1;
            n_done = 1'b0;
        end
    end

    // Shift the read history and queue the column write
    always_ff @(posedge i_clk) begin
        if (i_step.rd) begin
            r_h_mid <= i_step.seed ? r_first : q_mid;
        end
        if (i_step.pix) begin
            r_pix_d <= i_pixel;
        end
        if (i_step.first) begin
            r_first <= i_pixel;
        end
        r_wr_addr <= i_step.addr;
        r_wr_pix  <= i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= i_step.pix;
        end
    end

    // Move old middle row up, new pixel into the middle row
    assign o_wr_en   = r_wr_en;
    assign o_wr_addr = r_wr_addr;
    assign o_wr_data = {q_mid, r_wr_pix};

    // Load the work stage
    always_ff @(posedge i_clk) begin
        if (i_step.res) begin
            r_s1_two     <= i_step.two;
            r_s1_gx_zero <= i_step.gx_zero;
            r_s1_gy_zero <= i_step.gy_zero;
            r_s1_done    <= i_step.done;
            r_s1_left    <= r_h_mid;
            r_s1_up      <= q_above;
            r_s1_below   <= r_pix_d;
            r_s1_pix     <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else begin
            if (s1_emit) begin
                if (s1_final) begin
                    r_s1_valid <= 1'b0;
                end else begin
                    r_s1_phase <= 1'b1;
                end
            end
            if (i_step.res) begin
                r_s1_valid <= 1'b1;
                r_s1_phase <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_o_gx   <= n_gx;
            r_o_gy   <= n_gy;
            r_o_last <= n_last;
            r_o_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_o_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_grad_x = r_o_gx;
    assign o_grad_y = r_o_gy;
    assign o_last   = r_o_last;
    assign o_done   = r_o_done;

endmodule

// ===== test/cgxy_gradient_check.sv =====
`timescale 1ns / 100ps

// Watches the three channels of the gradient block, predicts every result from the
// accepted requests and register writes, and compares them in order.
module cgxy_gradient_check (
    input  logic i_clk,
    input  logic i_rst_n,
    cgxy_in_if   pix,
    cgxy_out_if  grad,
    cgxy_cfg_if  cfg,
    output int   o_open,
    output int   o_fails,
    output int   o_checked,
    output int   o_frames
);
    import cgxy_pkg::*;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic                     last_of_run;
        logic                     frame_done;
    } t_grad;

    t_grad awaited_q[$];
    t_grad want;

    // Predicted block state
    logic [PIXEL_BITS-1:0] row_above [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] row_mid [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] prev_pix [2];
    logic [ADDR_W-1:0]     col_pos;
    logic [ROW_W-1:0]      row_pos;
    logic [ADDR_W-1:0]     flush_pos;
    logic                  bottom_pending;
    logic [WIDTH_W-1:0]    width_cfg;
    logic [HEIGHT_W-1:0]   height_cfg;

    int fails;
    int checked;
    int frames;
    int v;

    function automatic void check_field(string name, integer exp_val, integer act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fails++;
        end
    endfunction

    function automatic void push_grad(int gx, int gy, logic last, logic done);
        t_grad e;
        e.grad_x      = GRAD_W'(gx);
        e.grad_y      = GRAD_W'(gy);
        e.last_of_run = last;
        e.frame_done  = done;
        awaited_q.push_back(e);
    endfunction

    // Right minus left on the middle row, zero on the border columns
    function automatic int central_x(int x);
        if (x == 0 || x + 1 >= int'(width_cfg)) return 0;
        return int'(row_mid[x + 1]) - int'(row_mid[x - 1]);
    endfunction

    function automatic void shift_column(int x, logic [PIXEL_BITS-1:0] p);
        row_above[x] = row_mid[x];
        row_mid[x]   = p;
    endfunction

    function automatic void restart_frame();
        col_pos        = '0;
        row_pos        = '0;
        flush_pos      = '0;
        bottom_pending = 1'b0;
        prev_pix[0]    = '0;
        prev_pix[1]    = '0;
    endfunction

    // Advance the prediction by one accepted request
    function automatic void compute_gradients(logic act, logic [PIXEL_BITS-1:0] px);
        int  w;
        int  h;
        int  c;
        int  r;
        int  gy;
        logic done;
        w = width_cfg;
        h = height_cfg;
        c = col_pos;
        r = row_pos;

        // Flush: one bottom-row result, or drop when the frame is not complete
        if (act == ACT_FLUSH) begin
            if (bottom_pending) begin
                done = (int'(flush_pos) + 1 >= w);
                push_grad(central_x(flush_pos), 0, 1'b1, done);
                if (done) restart_frame();
                else flush_pos = flush_pos + 1'b1;
            end
            return;
        end

        // Drop pixels while the bottom row waits for flush
        if (bottom_pending) return;

        // Result for the pixel one row up and one column left
        if (r >= 1 && c >= 1) begin
            gy = (r == 1) ? 0 : int'(prev_pix[0]) - int'(row_above[c - 1]);
            push_grad(central_x(c - 1), gy, (c + 1 != w), 1'b0);
            if (c + 1 == w) begin
                gy = (r == 1) ? 0 : int'(px) - int'(row_above[w - 1]);
                push_grad(0, gy, 1'b1, 1'b0);
            end
        end

        // Commit delayed pixels to the line buffers
        if (c >= 2) shift_column(c - 2, prev_pix[1]);
        if (c + 1 == w) begin
            shift_column(w - 2, prev_pix[0]);
            shift_column(w - 1, px);
        end
        prev_pix[1] = prev_pix[0];
        prev_pix[0] = px;

        // Advance the raster position
        if (c + 1 >= w) begin
            col_pos = '0;
            if (r + 1 >= h) bottom_pending = 1'b1;
            else row_pos = ROW_W'(r + 1);
        end else begin
            col_pos = ADDR_W'(c + 1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                row_above[i] = '0;
                row_mid[i]   = '0;
            end
            width_cfg  = WIDTH_W'(WIDTH_RESET);
            height_cfg = HEIGHT_W'(HEIGHT_RESET);
            restart_frame();
            awaited_q.delete();
        end else begin
            // Compare each result with the oldest expectation
            if (grad.valid && grad.ready) begin
                if (awaited_q.size() == 0) begin
                    $error("unexpected result: grad_x %0d grad_y %0d last %0b done %0b",
                           grad.grad_x, grad.grad_y, grad.last_of_run, grad.frame_done);
                    fails++;
                end else begin
                    want = awaited_q.pop_front();
                    check_field("grad_x", want.grad_x, grad.grad_x);
                    check_field("grad_y", want.grad_y, grad.grad_y);
                    check_field("last_of_run", want.last_of_run, grad.last_of_run);
                    check_field("frame_done", want.frame_done, grad.frame_done);
                    checked++;
                    if (want.frame_done) frames++;
                end
            end

            // Clamp written sizes; a write to either size register restarts the frame
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_FRAME_WIDTH: begin
                        v = int'(cfg.data[WIDTH_W-1:0]);
                        if (v < MIN_SIZE) v = MIN_SIZE;
                        if (v > MAX_WIDTH) v = MAX_WIDTH;
                        width_cfg = WIDTH_W'(v);
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT: begin
                        v = int'(cfg.data);
                        if (v < MIN_SIZE) v = MIN_SIZE;
                        if (v > MAX_HEIGHT) v = MAX_HEIGHT;
                        height_cfg = HEIGHT_W'(v);
                        restart_frame();
                    end
                    default: ;
                endcase
            end

            if (pix.valid && pix.ready) compute_gradients(pix.action, pix.pixel);
        end

        o_open    <= awaited_q.size();
        o_fails   <= fails;
        o_checked <= checked;
        o_frames  <= frames;
    end

endmodule

// ===== test/tb_central_difference_gradient_xy.sv =====
`timescale 1ns / 100ps

module tb_central_difference_gradient_xy;
    import cgxy_pkg::*;

    localparam int IDLE_PCT        = 16;
    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE          = 8;     // margin after the last predicted result
    localparam int RANDOM_REQUESTS = 480;
    localparam int PROBE_PIXELS    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    // Two 3x3 frames that drive the center gradients to both extremes
    localparam logic [PIXEL_BITS-1:0] EDGE_PATTERN [18] = '{
        8'd0,   8'd255, 8'd0,
        8'd0,   8'd128, 8'd255,
        8'd255, 8'd0,   8'd0,
        8'd255, 8'd0,   8'd255,
        8'd255, 8'd77,  8'd0,
        8'd0,   8'd255, 8'd255
    };

    logic i_clk;
    logic i_rst_n;

    cgxy_in_if  pix_if ();
    cgxy_out_if grad_if ();
    cgxy_cfg_if cfg_if ();

    int open_results;
    int fail_count;
    int checked_count;
    int frames_done;

    logic idle_on;
    int   frame_w;
    int   frame_h;
    int   requests_sent;
    int   frame_requests;
    int   settings_count;

    central_difference_gradient_xy dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_grad  (grad_if),
        .i_cfg   (cfg_if)
    );

    cgxy_gradient_check grad_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pix       (pix_if),
        .grad      (grad_if),
        .cfg       (cfg_if),
        .o_open    (open_results),
        .o_fails   (fail_count),
        .o_checked (checked_count),
        .o_frames  (frames_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        grad_if.ready <= !(idle_on && ($urandom_range(0, 99) < IDLE_PCT));
    end

    // End the run when no channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (grad_if.valid && grad_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("timeout: no channel moved for %0d cycles", STALL_LIMIT);
        $display("tb_central_difference_gradient_xy NOT OK");
        $finish;
    end

    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return PIXEL_BITS'($urandom_range(0, 255));
    endfunction

    // Offer one request, with random idle cycles in front, and hold it until taken
    task automatic send_request(logic act, logic [PIXEL_BITS-1:0] px);
        while (idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid  <= 1'b1;
        pix_if.action <= act;
        pix_if.pixel  <= px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic drain_results();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (open_results != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    // Write both size registers and track the clamped geometry
    task automatic set_geometry(logic [CFG_DATA_W-1:0] w_data, logic [CFG_DATA_W-1:0] h_data);
        write_reg(REG_FRAME_WIDTH, w_data);
        write_reg(REG_FRAME_HEIGHT, h_data);
        cfg_if.valid <= 1'b0;
        frame_w = int'(w_data[WIDTH_W-1:0]);
        frame_w = (frame_w < MIN_SIZE) ? MIN_SIZE : (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
        frame_h = int'(h_data);
        frame_h = (frame_h < MIN_SIZE) ? MIN_SIZE : (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
        settings_count++;
    endtask

    // Send one frame and its flushes; abandon it after cut pixels if cut is short
    task automatic play_frame(bit noisy, int cut);
        int total;
        total = frame_w * frame_h;
        for (int k = 0; k < total; k++) begin
            if (k == cut) begin
                drain_results();
                return;
            end
            if (noisy && $urandom_range(0, 49) == 0) drain_results();
            if (noisy && $urandom_range(0, 19) == 0) send_request(ACT_FLUSH, pick_pixel());
            send_request(ACT_PIXEL, pick_pixel());
            frame_requests++;
        end
        for (int k = 0; k < frame_w; k++) begin
            if (noisy && $urandom_range(0, 9) == 0) send_request(ACT_PIXEL, pick_pixel());
            send_request(ACT_FLUSH, pick_pixel());
            frame_requests++;
        end
    endtask

    initial begin
        int  round;
        int  total;
        int  cut;
        bit  recut;

        pix_if.valid   <= 1'b0;
        pix_if.action  <= ACT_PIXEL;
        pix_if.pixel   <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_FRAME_WIDTH;
        cfg_if.data    <= '0;
        i_rst_n        <= 1'b0;
        idle_on        <= 1'b1;
        frame_w        = WIDTH_RESET;
        frame_h        = HEIGHT_RESET;
        requests_sent  = 0;
        frame_requests = 0;
        settings_count = 1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: a few pixels of the first row yield nothing, then restart by a write
        play_frame(1'b0, PROBE_PIXELS);

        // Smallest frame, sizes clamped up from below
        set_geometry(CFG_DATA_W'(0), CFG_DATA_W'(2));
        send_request(ACT_FLUSH, 8'hFF);
        for (int k = 0; k < 9; k++) begin
            send_request(ACT_PIXEL, EDGE_PATTERN[k]);
            if (k == 4) drain_results();
        end
        send_request(ACT_PIXEL, 8'hFF);
        repeat (3) send_request(ACT_FLUSH, 8'h00);
        for (int k = 9; k < 18; k++) send_request(ACT_PIXEL, EDGE_PATTERN[k]);
        repeat (3) send_request(ACT_FLUSH, 8'hFF);
        drain_results();

        // Spare register indexes change nothing
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
        cfg_if.valid <= 1'b0;

        // Random small frames, some abandoned partway, with a stretch of no stalls
        frame_requests = 0;
        round = 0;
        recut = 1'b1;
        while (frame_requests < RANDOM_REQUESTS) begin
            idle_on <= !(round >= 4 && round < 9);
            if (recut || $urandom_range(0, 2) != 0) begin
                drain_results();
                set_geometry({1'($urandom_range(0, 1)), 12'($urandom_range(3, 8))},
                             CFG_DATA_W'($urandom_range(3, 6)));
            end
            total = frame_w * frame_h;
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
            recut = (cut < total);
            play_frame(1'b1, cut);
            round++;
        end

        // Widest and tallest frames, the large size clamped down from above, started and abandoned
        drain_results();
        idle_on <= 1'b1;
        set_geometry(CFG_DATA_W'(12'hFFF), CFG_DATA_W'(1));
        play_frame(1'b0, PROBE_PIXELS);
        drain_results();
        set_geometry(CFG_DATA_W'(3), CFG_DATA_W'(13'h1FFF));
        play_frame(1'b0, 8 * frame_w);
        drain_results();

        $display("Sent %0d requests over %0d frame geometries, widths 3 to %0d, heights 3 to %0d",
                 requests_sent, settings_count, MAX_WIDTH, MAX_HEIGHT);
        $display("Checked %0d gradient results, %0d frames finished, %0d failures",
                 checked_count, frames_done, fail_count);
        if (fail_count == 0 && open_results == 0) begin
            $display("tb_central_difference_gradient_xy OK");
        end else begin
            $display("tb_central_difference_gradient_xy NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cgxy_pkg.sv
rtl/core/cgxy_if.sv
rtl/core/cgxy_ram.sv
rtl/core/cgxy_ctrl.sv
rtl/core/cgxy_calc.sv
rtl/core/central_difference_gradient_xy.sv
test/cgxy_gradient_check.sv
test/tb_central_difference_gradient_xy.sv
